@@ rtl/core/stp_pkg.sv @@
// Shared types and constants for the software timer pool
`timescale 1ns / 1ps

package stp_pkg;

	// command codes
	typedef enum logic [3:0] {
		OP_TICK       = 4'd0,
		OP_CREATE     = 4'd1,
		OP_SET_PERIOD = 4'd2,
		OP_SET_MODE   = 4'd3,
		OP_DESTROY    = 4'd4,
		OP_RESET      = 4'd5,
		OP_START      = 4'd6,
		OP_STOP       = 4'd7,
		OP_READ       = 4'd8
	} opcode_t;

	// slot status codes
	localparam logic [1:0] ST_FREE = 2'd0;
	localparam logic [1:0] ST_IDLE = 2'd1;
	localparam logic [1:0] ST_RUN  = 2'd2;

	// width of the fired bitmap on the result
	localparam int MASK_W = 16;

	// sequencer states
	typedef enum logic {
		S_IDLE,
		S_RUN
	} state_t;

	// command item
	typedef struct packed {
		logic [3:0]  opcode;
		logic [3:0]  slot;
		logic [31:0] period;
		logic        one_shot;
	} cmd_t;

	// result item
	typedef struct packed {
		logic [MASK_W-1:0] fired_mask;
		logic [4:0]        slot_id;
		logic [31:0]       count;
		logic [1:0]        slot_state;
	} rsp_t;

	// one timer slot as stored in the slot memory
	typedef struct packed {
		logic [1:0]  status;
		logic        one_shot;
		logic [31:0] period;
		logic [31:0] count;
	} entry_t;

endpackage

@@ rtl/core/software_timer_pool.sv @@
// Top level of the software timer pool: command sequencer around the slot memory
//
// Usage:
//   cmd channel (cmd_valid, cmd_stall, cmd) carries one command item: tick, create,
//   set period, set mode, destroy, reset count, start, stop or read.
//   rsp channel (rsp_valid, rsp_stall, rsp) returns exactly one result item per command.
// Work per command:
//   tick: every slot in turn, one slot memory read-modify-write per cycle.
//   create: the walk stops at the lowest free slot.
//   commands on one slot: one read-modify-write; out-of-range slot or unknown code: none.
//   The single read and write port of the slot memory sets the pace of a walk; commands
//   are worked one at a time, the next is taken the cycle after a result is loaded.
// Reset: arst_n clears a valid bit per slot; a slot never written reads as free
//   with zero count, period and mode, so no clearing pass is needed.
// Stall: a result waits in the output register while rsp_stall is high; the next
//   command is still taken and worked, and its result waits until the register frees.
`timescale 1ns / 1ps

module software_timer_pool #(
	parameter int NUM_SLOTS = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cmd_valid,
	output logic          cmd_stall,
	input  stp_pkg::cmd_t cmd,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output stp_pkg::rsp_t rsp
);

	localparam int ADDR_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
	localparam int CMP_W = 8;
	localparam logic [ADDR_W-1:0] LAST_IDX = ADDR_W'(NUM_SLOTS - 1);

	stp_pkg::state_t state_q, state_d;
	stp_pkg::cmd_t   cmd_q;
	stp_pkg::rsp_t   res_q, res_d;
	stp_pkg::rsp_t   rsp_q;
	logic            rsp_valid_q;

	logic [ADDR_W-1:0]    idx_q;
	logic                 pend_q;
	logic                 found_q;
	logic                 rd_vld_s1;
	logic [ADDR_W-1:0]    rd_idx_s1;
	logic                 hit_s1;
	logic [NUM_SLOTS-1:0] slot_vld_q;

	logic            accept, done, load_out;
	logic            slot_ok, is_walk, is_single;
	logic            found_now;
	logic            wr_en;
	stp_pkg::entry_t wr_data, rd_data, ent;
	logic [31:0]     inc;
	logic [3:0]      fire_idx;

	// command decode at the input
	always_comb begin
		slot_ok = CMP_W'(cmd.slot) < CMP_W'(NUM_SLOTS);
		is_walk = (cmd.opcode == stp_pkg::OP_TICK) || (cmd.opcode == stp_pkg::OP_CREATE);
		is_single = slot_ok && (cmd.opcode >= stp_pkg::OP_SET_PERIOD)
			&& (cmd.opcode <= stp_pkg::OP_READ);
	end

	// sequencer next state and handshake
	always_comb begin
		accept = (state_q == stp_pkg::S_IDLE) && cmd_valid;
		done = (state_q == stp_pkg::S_RUN) && !pend_q && !rd_vld_s1;
		load_out = done && (!rsp_valid_q || !rsp_stall);
		state_d = state_q;
		case (state_q)
			stp_pkg::S_IDLE: begin
				if (accept) begin
					state_d = stp_pkg::S_RUN;
				end
			end
			stp_pkg::S_RUN: begin
				if (load_out) begin
					state_d = stp_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = stp_pkg::S_IDLE;
			end
		endcase
	end

	assign cmd_stall = (state_q != stp_pkg::S_IDLE);

	// modify stage: entry read last cycle is updated and written back
	always_comb begin
		ent = hit_s1 ? rd_data : '0;
		inc = ent.count + 32'd1;
		fire_idx = 4'(rd_idx_s1);
		wr_en = 1'b0;
		wr_data = ent;
		res_d = res_q;
		found_now = 1'b0;
		if (rd_vld_s1) begin
			case (cmd_q.opcode)
				stp_pkg::OP_TICK: begin
					if (ent.status == stp_pkg::ST_RUN) begin
						wr_en = 1'b1;
						if (inc >= ent.period) begin
							wr_data.count = '0;
							if (ent.one_shot) begin
								wr_data.status = stp_pkg::ST_IDLE;
							end
							if (CMP_W'(rd_idx_s1) < CMP_W'(stp_pkg::MASK_W)) begin
								res_d.fired_mask[fire_idx] = 1'b1;
							end
						end else begin
							wr_data.count = inc;
						end
					end
				end
				stp_pkg::OP_CREATE: begin
					if (!found_q && ent.status == stp_pkg::ST_FREE) begin
						wr_en = 1'b1;
						wr_data.status = stp_pkg::ST_IDLE;
						wr_data.one_shot = cmd_q.one_shot;
						wr_data.period = cmd_q.period;
						wr_data.count = '0;
						res_d.slot_id = 5'(rd_idx_s1);
						found_now = 1'b1;
					end
				end
				stp_pkg::OP_SET_PERIOD: begin
					wr_en = 1'b1;
					wr_data.period = cmd_q.period;
				end
				stp_pkg::OP_SET_MODE: begin
					wr_en = 1'b1;
					wr_data.one_shot = cmd_q.one_shot;
				end
				stp_pkg::OP_DESTROY: begin
					wr_en = 1'b1;
					wr_data.count = '0;
					wr_data.status = stp_pkg::ST_FREE;
				end
				stp_pkg::OP_RESET: begin
					wr_en = 1'b1;
					wr_data.count = '0;
				end
				stp_pkg::OP_START: begin
					wr_en = 1'b1;
					wr_data.count = '0;
					if (ent.status != stp_pkg::ST_FREE) begin
						wr_data.status = stp_pkg::ST_RUN;
					end
				end
				stp_pkg::OP_STOP: begin
					wr_en = 1'b1;
					wr_data.count = '0;
					if (ent.status != stp_pkg::ST_FREE) begin
						wr_data.status = stp_pkg::ST_IDLE;
					end
				end
				stp_pkg::OP_READ: begin
					res_d.count = ent.count;
					res_d.slot_state = ent.status;
				end
				default: begin
					wr_en = 1'b0;
				end
			endcase
		end
	end

	// slot memory; read and write of one command never hit the same entry in one cycle
	stp_slot_ram #(
		.DEPTH  (NUM_SLOTS),
		.ADDR_W (ADDR_W)
	) u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (rd_idx_s1),
		.wr_data (wr_data),
		.rd_en   (pend_q),
		.rd_addr (idx_q),
		.rd_data (rd_data)
	);

	// walk commands keep reading; single-slot commands read once
	function automatic logic is_walk_q();
		return (cmd_q.opcode == stp_pkg::OP_TICK) || (cmd_q.opcode == stp_pkg::OP_CREATE);
	endfunction

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= stp_pkg::S_IDLE;
			pend_q <= 1'b0;
			found_q <= 1'b0;
			rd_vld_s1 <= 1'b0;
			slot_vld_q <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			rd_vld_s1 <= (state_q == stp_pkg::S_RUN) && pend_q;
			if (accept) begin
				pend_q <= is_walk || is_single;
				found_q <= 1'b0;
			end else if (pend_q) begin
				pend_q <= is_walk_q() && (idx_q != LAST_IDX) && !found_now;
			end
			if (found_now) begin
				found_q <= 1'b1;
			end
			if (wr_en) begin
				slot_vld_q[rd_idx_s1] <= 1'b1;
			end
			if (load_out) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q <= cmd;
			idx_q <= is_walk ? '0 : ADDR_W'(cmd.slot);
			res_q <= '{fired_mask: '0,
				slot_id: (cmd.opcode == stp_pkg::OP_CREATE) ? 5'(NUM_SLOTS) : 5'd0,
				count: '0, slot_state: '0};
		end else begin
			if (pend_q) begin
				idx_q <= idx_q + 1'b1;
			end
			res_q <= res_d;
		end
		rd_idx_s1 <= idx_q;
		hit_s1 <= slot_vld_q[idx_q];
		if (load_out) begin
			rsp_q <= res_q;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp = rsp_q;

endmodule

@@ rtl/core/stp_slot_ram.sv @@
// Slot memory: one write port, one read port with registered read data
`timescale 1ns / 1ps

module stp_slot_ram #(
	parameter int DEPTH  = 16,
	parameter int ADDR_W = 4
) (
	input  logic                clk,
	input  logic                wr_en,
	input  logic [ADDR_W-1:0]   wr_addr,
	input  stp_pkg::entry_t     wr_data,
	input  logic                rd_en,
	input  logic [ADDR_W-1:0]   rd_addr,
	output stp_pkg::entry_t     rd_data
);

	stp_pkg::entry_t mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// read port, registered read data
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

@@ rtl/core/stp_checker.sv @@
// Port-level checker for the software timer pool, bound to the top level
`timescale 1ns / 1ps

module stp_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          cmd_valid,
	input logic          cmd_stall,
	input stp_pkg::cmd_t cmd,
	input logic          rsp_valid,
	input logic          rsp_stall,
	input stp_pkg::rsp_t rsp
);

	// a stalled result item holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("stalled result item changed");

	// one command at a time: busy right after an accept
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && !cmd_stall |=> cmd_stall)
		else $error("command taken while previous item in work");

	// a result carries fields of one command kind only
	a_one_kind: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> $countones({rsp.fired_mask != '0, rsp.slot_id != '0,
			(rsp.count != '0) || (rsp.slot_state != stp_pkg::ST_FREE)}) <= 1)
		else $error("result mixes fields of several commands");

	// a nonzero count is only ever seen on a running slot
	a_count_running: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp.count != '0) |-> rsp.slot_state == stp_pkg::ST_RUN)
		else $error("nonzero count on a slot that is not running");

endmodule

bind software_timer_pool stp_checker u_stp_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.cmd_valid (cmd_valid),
	.cmd_stall (cmd_stall),
	.cmd       (cmd),
	.rsp_valid (rsp_valid),
	.rsp_stall (rsp_stall),
	.rsp       (rsp)
);

@@ verif/tb.sv @@
// Testbench for the software timer pool: command stimulus, slot-state prediction and result checks
`timescale 1ns / 1ps

module tb;
	import stp_pkg::*;

	localparam int NUM_SLOTS     = 16;
	localparam int RANDOM_ITEMS  = 450;
	localparam int RANDOM_PHASES = 6;
	localparam int MAX_IDLE      = 8;
	localparam int QUIET_LIMIT   = 2000;
	localparam int DRAIN_CYCLES  = 4 * NUM_SLOTS;

	// codes outside the command set
	localparam logic [3:0]  OP_UNKNOWN_LO = 4'd9;
	localparam logic [3:0]  OP_UNKNOWN_HI = 4'd15;
	localparam logic [31:0] PERIOD_MAX    = 32'hFFFF_FFFF;

	// timer slot state predictor and queue of expected results
	class timer_pool_scoreboard;
		bit [1:0]  status_of   [NUM_SLOTS];
		bit [31:0] count_of    [NUM_SLOTS];
		bit [31:0] period_of   [NUM_SLOTS];
		bit        one_shot_of [NUM_SLOTS];
		rsp_t      expected_rsps [$];
		int        mismatches;

		function int first_free();
			int i;
			i = 0;
			while (i < NUM_SLOTS && status_of[i] != ST_FREE)
				i++;
			return i;
		endfunction

		function int pending();
			return expected_rsps.size();
		endfunction

		// apply one command to the slot state, return the result it must produce
		function rsp_t predict_result(cmd_t c);
			rsp_t want;
			int   free_slot;
			bit   in_pool;
			want = '0;
			in_pool = c.slot < NUM_SLOTS;
			case (c.opcode)
				OP_TICK: begin
					for (int i = 0; i < NUM_SLOTS; i++) begin
						if (status_of[i] == ST_RUN) begin
							count_of[i] += 1;
							if (count_of[i] >= period_of[i]) begin
								if (i < MASK_W)
									want.fired_mask[i] = 1'b1;
								count_of[i] = 0;
								if (one_shot_of[i])
									status_of[i] = ST_IDLE;
							end
						end
					end
				end
				OP_CREATE: begin
					free_slot = first_free();
					if (free_slot < NUM_SLOTS) begin
						one_shot_of[free_slot] = c.one_shot;
						status_of[free_slot]   = ST_IDLE;
						period_of[free_slot]   = c.period;
						count_of[free_slot]    = 0;
					end
					want.slot_id = free_slot[4:0];
				end
				OP_SET_PERIOD: if (in_pool) period_of[c.slot] = c.period;
				OP_SET_MODE:   if (in_pool) one_shot_of[c.slot] = c.one_shot;
				OP_DESTROY: if (in_pool) begin
					count_of[c.slot]  = 0;
					status_of[c.slot] = ST_FREE;
				end
				OP_RESET: if (in_pool) count_of[c.slot] = 0;
				OP_START: if (in_pool) begin
					count_of[c.slot] = 0;
					if (status_of[c.slot] != ST_FREE)
						status_of[c.slot] = ST_RUN;
				end
				OP_STOP: if (in_pool) begin
					if (status_of[c.slot] != ST_FREE)
						status_of[c.slot] = ST_IDLE;
					count_of[c.slot] = 0;
				end
				OP_READ: if (in_pool) begin
					want.count      = count_of[c.slot];
					want.slot_state = status_of[c.slot];
				end
				default: ;
			endcase
			return want;
		endfunction

		function void note_command(cmd_t c);
			expected_rsps.push_back(predict_result(c));
		endfunction

		function void check_result(rsp_t got);
			rsp_t want;
			if (expected_rsps.size() == 0) begin
				$error("result item arrived with no command outstanding");
				mismatches++;
				return;
			end
			want = expected_rsps.pop_front();
			if (got.fired_mask !== want.fired_mask) begin
				$error("fired_mask: expected %h, got %h", want.fired_mask, got.fired_mask);
				mismatches++;
			end
			if (got.slot_id !== want.slot_id) begin
				$error("slot_id: expected %0d, got %0d", want.slot_id, got.slot_id);
				mismatches++;
			end
			if (got.count !== want.count) begin
				$error("count: expected %h, got %h", want.count, got.count);
				mismatches++;
			end
			if (got.slot_state !== want.slot_state) begin
				$error("slot_state: expected %0d, got %0d", want.slot_state, got.slot_state);
				mismatches++;
			end
		endfunction
	endclass

	logic clk       = 1'b0;
	logic arst_n    = 1'b0;
	logic cmd_valid = 1'b0;
	logic cmd_stall;
	cmd_t cmd       = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	rsp_t rsp;

	bit steady       = 1'b0;
	int items_sent   = 0;
	int quiet_cycles = 0;

	timer_pool_scoreboard timers = new;

	software_timer_pool #(
		.NUM_SLOTS(NUM_SLOTS)
	) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.cmd       (cmd),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic int idle_cycles();
		if (steady)
			return 0;
		return $urandom_range(0, MAX_IDLE);
	endfunction

	// mostly the low slots, where timers tend to exist
	function automatic int pick_slot();
		if ($urandom_range(0, 9) < 7)
			return $urandom_range(0, 5);
		return $urandom_range(0, NUM_SLOTS - 1);
	endfunction

	// mostly short periods so that timers fire often
	function automatic logic [31:0] pick_period();
		int unsigned r;
		r = $urandom_range(0, 19);
		if (r == 0)
			return '0;
		if (r < 3)
			return $urandom;
		return $urandom_range(1, 6);
	endfunction

	// present one command item after a random gap and hold it until taken
	task automatic send_command(input logic [3:0] op, input int slot, input logic [31:0] per,
			input int os);
		cmd_t c;
		int   gap;
		c.opcode   = op;
		c.slot     = slot[3:0];
		c.period   = per;
		c.one_shot = os[0];
		gap = idle_cycles();
		if (gap > 0) begin
			cmd_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd_valid <= 1'b1;
		cmd       <= c;
		do @(posedge clk); while (cmd_stall);
		timers.note_command(c);
		items_sent++;
	endtask

	task automatic hold_until_drained();
		cmd_valid <= 1'b0;
		do @(posedge clk); while (timers.pending() != 0);
	endtask

	// one command of any kind, with random content in every field
	task automatic random_command();
		int unsigned pick;
		logic [3:0]  op;
		pick = $urandom_range(0, 99);
		if (pick < 35)      op = OP_TICK;
		else if (pick < 45) op = OP_CREATE;
		else if (pick < 53) op = OP_SET_PERIOD;
		else if (pick < 58) op = OP_SET_MODE;
		else if (pick < 63) op = OP_DESTROY;
		else if (pick < 67) op = OP_RESET;
		else if (pick < 79) op = OP_START;
		else if (pick < 84) op = OP_STOP;
		else if (pick < 98) op = OP_READ;
		else                op = 4'($urandom_range(OP_UNKNOWN_LO, OP_UNKNOWN_HI));
		send_command(op, pick_slot(), pick_period(), $urandom_range(0, 1));
	endtask

	// create a timer, run it for a few ticks, then stop it, free it, switch its mode or leave it running
	task automatic run_lifecycle();
		int s;
		int n;
		s = timers.first_free();
		if (s >= NUM_SLOTS)
			s = pick_slot();
		send_command(OP_CREATE, pick_slot(), pick_period(), $urandom_range(0, 1));
		if ($urandom_range(0, 3) == 0)
			send_command(OP_SET_PERIOD, s, pick_period(), $urandom_range(0, 1));
		send_command(OP_START, s, $urandom, $urandom_range(0, 1));
		n = $urandom_range(1, 8);
		repeat (n) begin
			send_command(OP_TICK, pick_slot(), $urandom, $urandom_range(0, 1));
			if ($urandom_range(0, 2) == 0)
				send_command(OP_READ, s, $urandom, $urandom_range(0, 1));
		end
		case ($urandom_range(0, 3))
			0: send_command(OP_STOP, s, $urandom, $urandom_range(0, 1));
			1: send_command(OP_DESTROY, s, $urandom, $urandom_range(0, 1));
			2: send_command(OP_SET_MODE, s, $urandom, $urandom_range(0, 1));
			default: ;
		endcase
	endtask

	// result side: random stall before each result item
	initial begin
		int stall_len;
		while (!arst_n) @(posedge clk);
		forever begin
			stall_len = idle_cycles();
			if (stall_len > 0) begin
				rsp_stall <= 1'b1;
				repeat (stall_len) @(posedge clk);
			end
			rsp_stall <= 1'b0;
			do @(posedge clk); while (!rsp_valid);
		end
	end

	// result checking and watchdog on handshake activity
	always @(posedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall)
			timers.check_result(rsp);
		if ((cmd_valid && !cmd_stall) || (rsp_valid && !rsp_stall)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("end of test: mismatches");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// stimulus
	initial begin
		int directed_end;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty pool: read a free slot, tick with nothing running
		send_command(OP_READ, 0, 0, 0);
		send_command(OP_TICK, 0, 0, 0);
		// zero period fires on every tick
		send_command(OP_CREATE, 0, 0, 0);
		send_command(OP_START, 0, 0, 0);
		send_command(OP_TICK, 0, 0, 0);
		// one-shot timer fires once and goes idle
		send_command(OP_CREATE, 0, 3, 1);
		send_command(OP_START, 1, 0, 0);
		repeat (3) send_command(OP_TICK, NUM_SLOTS - 1, PERIOD_MAX, 1);
		send_command(OP_READ, 1, 0, 0);
		// longest period, then period lowered below the count
		send_command(OP_SET_PERIOD, 0, PERIOD_MAX, 0);
		send_command(OP_TICK, 0, 0, 0);
		send_command(OP_READ, 0, 0, 0);
		send_command(OP_SET_PERIOD, 0, 0, 0);
		send_command(OP_TICK, 0, 0, 0);
		// periodic timer switched to one-shot
		send_command(OP_SET_MODE, 0, 0, 1);
		send_command(OP_TICK, 0, 0, 0);
		// destroy, then commands on free slots
		send_command(OP_DESTROY, 1, 0, 0);
		send_command(OP_READ, 1, 0, 0);
		send_command(OP_START, NUM_SLOTS - 1, PERIOD_MAX, 1);
		send_command(OP_STOP, NUM_SLOTS - 1, PERIOD_MAX, 1);
		send_command(OP_RESET, NUM_SLOTS - 1, PERIOD_MAX, 1);
		send_command(OP_SET_PERIOD, NUM_SLOTS - 1, PERIOD_MAX, 1);
		send_command(OP_READ, NUM_SLOTS - 1, PERIOD_MAX, 1);
		// codes outside the command set
		send_command(OP_UNKNOWN_LO, NUM_SLOTS - 1, PERIOD_MAX, 1);
		send_command(OP_UNKNOWN_HI, 0, 0, 0);
		directed_end = items_sent;

		// random phases, the sender drains the block between phases
		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			steady = (phase == 2);
			if (phase == 3) begin
				// fill the pool past its size, then free part of it
				repeat (NUM_SLOTS + 2)
					send_command(OP_CREATE, pick_slot(), pick_period(), $urandom_range(0, 1));
				repeat (6)
					send_command(OP_DESTROY, $urandom_range(0, NUM_SLOTS - 1), pick_period(),
						$urandom_range(0, 1));
			end
			while (items_sent < directed_end + (phase + 1) * RANDOM_ITEMS / RANDOM_PHASES) begin
				if ($urandom_range(0, 9) < 4)
					run_lifecycle();
				else
					random_command();
			end
			hold_until_drained();
		end
		steady = 1'b0;

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (timers.mismatches == 0 && timers.pending() == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
